>>> hdl/http_request_line_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// http_request_line_tokenizer_defines
// Assertion macros shared by the request line tokeniser.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_LINE_TOKENIZER_DEFINES_SVH
`define HTTP_REQUEST_LINE_TOKENIZER_DEFINES_SVH

// same-cycle implication, masked during reset
`define HRLT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrlt: same-cycle check failed");

// next-cycle implication, masked during reset
`define HRLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrlt: next-cycle check failed");

`endif

>>> hdl/hrlt_pkg.sv
// ----------------------------------------------------------------------------
// hrlt_pkg
// Types, limits and codes for the HTTP request line tokeniser.
// ----------------------------------------------------------------------------
package hrlt_pkg;

   // limits
   localparam int MAX_PATH     = 1024;
   localparam int MAX_SEGMENTS = 32;
   localparam int MAX_PAIRS    = 32;
   localparam int PATH_LEN_W   = $clog2(MAX_PATH + 1);
   localparam int CNT_W        = 6;
   localparam logic [CNT_W-1:0] MAX_PAIRS_RESET = CNT_W'(32);

   // decoupling queue between front and back
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // characters
   localparam logic [7:0] CHAR_G     = 8'h47;
   localparam logic [7:0] CHAR_D     = 8'h44;
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_O     = 8'h4F;
   localparam logic [7:0] CHAR_U     = 8'h55;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_QUEST = 8'h3F;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   // character classes produced by the front end
   localparam logic [2:0] CLS_OTHER = 3'd0;
   localparam logic [2:0] CLS_SPACE = 3'd1;
   localparam logic [2:0] CLS_QUEST = 3'd2;
   localparam logic [2:0] CLS_SLASH = 3'd3;
   localparam logic [2:0] CLS_AMP   = 3'd4;
   localparam logic [2:0] CLS_EQUAL = 3'd5;

   // byte kinds
   localparam logic [2:0] KIND_METHOD  = 3'd0;
   localparam logic [2:0] KIND_SEGMENT = 3'd1;
   localparam logic [2:0] KIND_KEY     = 3'd2;
   localparam logic [2:0] KIND_VALUE   = 3'd3;
   localparam logic [2:0] KIND_SEP     = 3'd4;
   localparam logic [2:0] KIND_IGNORED = 3'd5;

   // method codes
   localparam logic [2:0] METHOD_UNKNOWN = 3'd0;
   localparam logic [2:0] METHOD_GET     = 3'd1;
   localparam logic [2:0] METHOD_DELETE  = 3'd2;
   localparam logic [2:0] METHOD_POST    = 3'd3;
   localparam logic [2:0] METHOD_PUT     = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       line_end;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic [2:0]       byte_kind;
      logic [2:0]       method_code;
      logic [CNT_W-1:0] segment_index;
      logic [CNT_W-1:0] pair_index;
      logic             token_start;
      logic             pair_closed;
      logic             pair_kept;
      logic             overflow;
      logic             last;
   } rsp_payload_type;

   // classified byte passed from front to back
   typedef struct packed {
      req_payload_type payload;
      logic [2:0]      char_class;
   } item_type;

   // queue handshake seen from one side
   typedef struct packed {
      logic push;
      logic full;
   } qwr_ctrl_type;

   typedef struct packed {
      logic pop;
      logic empty;
   } qrd_ctrl_type;

endpackage

>>> hdl/http_request_line_tokenizer.sv
// ----------------------------------------------------------------------------
// http_request_line_tokenizer
// Tags every byte of an HTTP request line with its role.
// ----------------------------------------------------------------------------
// Usage:
//  - Bytes go in on the req_ side as a queue: one transaction is taken at a
//    clock edge with req_push high and req_full low.
//  - Each byte gives exactly one result on the rsp_ side, oldest first, shown
//    while rsp_empty is low and taken with rsp_pop.
//  - From input transaction to result visible, the byte is written into the
//    classification queue, then the parser pops it and writes its result into
//    the result queue, from which rsp_pop takes it.
//  - Throughput is one byte per cycle while the result queue is not full;
//    both queues hold two entries, so a result waiting does not stop intake.
//  - When the receiver stalls the result queue fills, the parser holds, the
//    input queue fills and req_full rises; nothing is lost.
//  - csr_wr_data sets the query pair limit (reset 32) via csr_wr_en; the user
//    writes it only while the block is idle; the block does not enforce this.
//  - Synchronous reset empties both queues and returns the parser to the
//    method phase with the limit at 32. Setting line_end on a byte returns
//    the parser to the method phase after that byte.
// ----------------------------------------------------------------------------
`include "http_request_line_tokenizer_defines.svh"

module http_request_line_tokenizer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  hrlt_pkg::req_payload_type  req_payload,
   output logic                       req_full,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output hrlt_pkg::rsp_payload_type  rsp_payload,
   input  logic                       csr_wr_en,
   input  logic [hrlt_pkg::CNT_W-1:0] csr_wr_data
);

   hrlt_pkg::item_type     fq_item, bq_item;
   hrlt_pkg::qwr_ctrl_type wr_ctrl;
   hrlt_pkg::qrd_ctrl_type rd_ctrl;
   logic                   q_push, q_full, q_pop, q_empty;

   assign wr_ctrl.push  = q_push;
   assign wr_ctrl.full  = q_full;
   assign rd_ctrl.pop   = q_pop;
   assign rd_ctrl.empty = q_empty;

   // front end: intake and classification
   hrlt_front u_front (
      .req_push    (req_push),
      .req_payload (req_payload),
      .req_full    (req_full),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (fq_item)
   );

   // decoupling queue
   hrlt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .wr_ctrl_in (wr_ctrl),
      .wr_item    (fq_item),
      .full       (q_full),
      .rd_ctrl_in (rd_ctrl),
      .rd_item    (bq_item),
      .empty      (q_empty)
   );

   // back end: parser and result queue
   hrlt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_item      (bq_item),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

   // checks
   `HRLT_ASSERT_IMPLY(a_closed_is_sep, clock, reset,
      !rsp_empty && rsp_payload.pair_closed, rsp_payload.byte_kind == hrlt_pkg::KIND_SEP)
   `HRLT_ASSERT_IMPLY(a_overflow_ignored, clock, reset,
      !rsp_empty && rsp_payload.overflow, rsp_payload.byte_kind == hrlt_pkg::KIND_IGNORED)
   `HRLT_ASSERT_IMPLY(a_start_in_token, clock, reset,
      !rsp_empty && rsp_payload.token_start,
      rsp_payload.byte_kind == hrlt_pkg::KIND_SEGMENT ||
      rsp_payload.byte_kind == hrlt_pkg::KIND_KEY ||
      rsp_payload.byte_kind == hrlt_pkg::KIND_VALUE)
   `HRLT_ASSERT_NEXT(a_pop_drains, clock, reset,
      q_pop && !q_push && q_full, !q_full)

endmodule

>>> hdl/hrlt_front.sv
// ----------------------------------------------------------------------------
// hrlt_front
// Accepts request bytes and tags each with its character class.
// ----------------------------------------------------------------------------
module hrlt_front (
   input  logic                     req_push,
   input  hrlt_pkg::req_payload_type req_payload,
   output logic                     req_full,
   input  logic                     q_full,
   output logic                     q_push,
   output hrlt_pkg::item_type       q_item
);

   logic [2:0] cls;

   // character classification
   always_comb begin
      case (req_payload.data_byte)
         hrlt_pkg::CHAR_SPACE: cls = hrlt_pkg::CLS_SPACE;
         hrlt_pkg::CHAR_QUEST: cls = hrlt_pkg::CLS_QUEST;
         hrlt_pkg::CHAR_SLASH: cls = hrlt_pkg::CLS_SLASH;
         hrlt_pkg::CHAR_AMP:   cls = hrlt_pkg::CLS_AMP;
         hrlt_pkg::CHAR_EQUAL: cls = hrlt_pkg::CLS_EQUAL;
         default:              cls = hrlt_pkg::CLS_OTHER;
      endcase
   end

   // a transaction goes straight into the queue
   assign req_full          = q_full;
   assign q_push            = req_push & ~q_full;
   assign q_item.payload    = req_payload;
   assign q_item.char_class = cls;

endmodule

>>> hdl/hrlt_queue.sv
// ----------------------------------------------------------------------------
// hrlt_queue
// Short queue of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module hrlt_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  hrlt_pkg::qwr_ctrl_type wr_ctrl_in,
   input  hrlt_pkg::item_type     wr_item,
   output logic                   full,
   input  hrlt_pkg::qrd_ctrl_type rd_ctrl_in,
   output hrlt_pkg::item_type     rd_item,
   output logic                   empty
);

   hrlt_pkg::item_type                 mem_ff [hrlt_pkg::QDEPTH];
   logic [hrlt_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [hrlt_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [hrlt_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                               do_push, do_pop;

   assign full    = (count_ff == hrlt_pkg::QCNT_W'(hrlt_pkg::QDEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = wr_ctrl_in.push & ~full;
   assign do_pop  = rd_ctrl_in.pop & ~empty;
   assign rd_item = mem_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == hrlt_pkg::QPTR_W'(hrlt_pkg::QDEPTH - 1)) ?
                     '0 : wr_ptr_ff + hrlt_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == hrlt_pkg::QPTR_W'(hrlt_pkg::QDEPTH - 1)) ?
                     '0 : rd_ptr_ff + hrlt_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + hrlt_pkg::QCNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - hrlt_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

>>> hdl/hrlt_back.sv
// ----------------------------------------------------------------------------
// hrlt_back
// Request line state machine and result queue.
// ----------------------------------------------------------------------------
module hrlt_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [hrlt_pkg::CNT_W-1:0] csr_wr_data,
   input  hrlt_pkg::item_type        q_item,
   input  logic                      q_empty,
   output logic                      q_pop,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output hrlt_pkg::rsp_payload_type rsp_payload
);

   localparam logic [1:0] PH_METHOD = 2'd0;
   localparam logic [1:0] PH_PATH   = 2'd1;
   localparam logic [1:0] PH_QUERY  = 2'd2;
   localparam logic [1:0] PH_TAIL   = 2'd3;

   localparam int CW = hrlt_pkg::CNT_W;
   localparam int PW = hrlt_pkg::PATH_LEN_W;

   // configuration
   logic [CW-1:0] max_pairs_ff;
   logic [CW-1:0] limit;

   // parser state
   logic [1:0]    phase_ff, phase_in;
   logic [7:0]    first_byte_ff, first_byte_in;
   logic [1:0]    byte_pos_ff, byte_pos_in;
   logic [2:0]    method_ff, method_in;
   logic [CW-1:0] seg_count_ff, seg_count_in;
   logic          in_seg_ff, in_seg_in;
   logic [CW-1:0] pair_count_ff, pair_count_in;
   logic          seen_eq_ff, seen_eq_in;
   logic [PW-1:0] path_len_ff, path_len_in;

   // result queue
   hrlt_pkg::rsp_payload_type    res_mem_ff [hrlt_pkg::QDEPTH];
   logic [hrlt_pkg::QPTR_W-1:0]  res_wr_ff, res_wr_in;
   logic [hrlt_pkg::QPTR_W-1:0]  res_rd_ff, res_rd_in;
   logic [hrlt_pkg::QCNT_W-1:0]  res_cnt_ff, res_cnt_in;
   logic                         res_full, res_pop;

   hrlt_pkg::rsp_payload_type res;
   logic [7:0]                b;
   logic [2:0]                cls;

   assign b     = q_item.payload.data_byte;
   assign cls   = q_item.char_class;
   assign limit = (max_pairs_ff < CW'(hrlt_pkg::MAX_PAIRS)) ?
                  max_pairs_ff : CW'(hrlt_pkg::MAX_PAIRS);

   assign res_full  = (res_cnt_ff == hrlt_pkg::QCNT_W'(hrlt_pkg::QDEPTH));
   assign rsp_empty = (res_cnt_ff == '0);
   assign res_pop   = rsp_pop & ~rsp_empty;
   assign q_pop     = ~q_empty & ~res_full;
   assign rsp_payload = res_mem_ff[res_rd_ff];

   // per-byte classification and next state
   always_comb begin
      phase_in      = phase_ff;
      first_byte_in = first_byte_ff;
      byte_pos_in   = byte_pos_ff;
      method_in     = method_ff;
      seg_count_in  = seg_count_ff;
      in_seg_in     = in_seg_ff;
      pair_count_in = pair_count_ff;
      seen_eq_in    = seen_eq_ff;
      path_len_in   = path_len_ff;

      res.out_byte      = b;
      res.byte_kind     = hrlt_pkg::KIND_IGNORED;
      res.method_code   = method_ff;
      res.segment_index = '0;
      res.pair_index    = '0;
      res.token_start   = 1'b0;
      res.pair_closed   = 1'b0;
      res.pair_kept     = 1'b0;
      res.overflow      = 1'b0;
      res.last          = q_item.payload.line_end;

      case (phase_ff)
         PH_METHOD: begin
            if (byte_pos_ff == 2'd0) begin
               first_byte_in = b;
            end
            if (byte_pos_ff == 2'd1) begin
               if (first_byte_ff == hrlt_pkg::CHAR_G) begin
                  method_in = hrlt_pkg::METHOD_GET;
               end else if (first_byte_ff == hrlt_pkg::CHAR_D) begin
                  method_in = hrlt_pkg::METHOD_DELETE;
               end else if (first_byte_ff == hrlt_pkg::CHAR_P &&
                            b == hrlt_pkg::CHAR_O) begin
                  method_in = hrlt_pkg::METHOD_POST;
               end else if (first_byte_ff == hrlt_pkg::CHAR_P &&
                            b == hrlt_pkg::CHAR_U) begin
                  method_in = hrlt_pkg::METHOD_PUT;
               end else begin
                  method_in = hrlt_pkg::METHOD_UNKNOWN;
               end
            end
            if (byte_pos_ff != 2'd2) begin
               byte_pos_in = byte_pos_ff + 2'd1;
            end
            if (cls == hrlt_pkg::CLS_SPACE) begin
               res.byte_kind = hrlt_pkg::KIND_SEP;
               phase_in      = PH_PATH;
            end else begin
               res.byte_kind = hrlt_pkg::KIND_METHOD;
            end
         end
         PH_PATH: begin
            if (cls == hrlt_pkg::CLS_SPACE) begin
               res.byte_kind = hrlt_pkg::KIND_SEP;
               phase_in      = PH_TAIL;
            end else if (cls == hrlt_pkg::CLS_QUEST) begin
               res.byte_kind = hrlt_pkg::KIND_SEP;
               phase_in      = PH_QUERY;
               in_seg_in     = 1'b0;
               seen_eq_in    = 1'b0;
            end else if (path_len_ff >= PW'(hrlt_pkg::MAX_PATH)) begin
               res.overflow = 1'b1;
            end else begin
               path_len_in = path_len_ff + PW'(1);
               if (cls == hrlt_pkg::CLS_SLASH) begin
                  res.byte_kind = hrlt_pkg::KIND_SEP;
                  in_seg_in     = 1'b0;
               end else if (in_seg_ff) begin
                  res.byte_kind     = hrlt_pkg::KIND_SEGMENT;
                  res.segment_index = seg_count_ff - CW'(1);
               end else if (seg_count_ff >= CW'(hrlt_pkg::MAX_SEGMENTS)) begin
                  res.overflow = 1'b1;
               end else begin
                  res.byte_kind     = hrlt_pkg::KIND_SEGMENT;
                  res.token_start   = 1'b1;
                  res.segment_index = seg_count_ff;
                  seg_count_in      = seg_count_ff + CW'(1);
                  in_seg_in         = 1'b1;
               end
            end
         end
         PH_QUERY: begin
            if (cls == hrlt_pkg::CLS_SPACE) begin
               res.byte_kind = hrlt_pkg::KIND_SEP;
               phase_in      = PH_TAIL;
               if (pair_count_ff < limit) begin
                  res.pair_closed = 1'b1;
                  res.pair_kept   = seen_eq_ff;
                  res.pair_index  = pair_count_ff;
                  if (seen_eq_ff) begin
                     pair_count_in = pair_count_ff + CW'(1);
                  end
               end
            end else if (pair_count_ff >= limit) begin
               res.byte_kind = hrlt_pkg::KIND_IGNORED;
            end else if (cls == hrlt_pkg::CLS_AMP) begin
               res.byte_kind   = hrlt_pkg::KIND_SEP;
               res.pair_closed = 1'b1;
               res.pair_kept   = seen_eq_ff;
               res.pair_index  = pair_count_ff;
               if (seen_eq_ff) begin
                  pair_count_in = pair_count_ff + CW'(1);
               end
               seen_eq_in = 1'b0;
               in_seg_in  = 1'b0;
            end else if (cls == hrlt_pkg::CLS_EQUAL && !seen_eq_ff) begin
               res.byte_kind  = hrlt_pkg::KIND_SEP;
               res.pair_index = pair_count_ff;
               seen_eq_in     = 1'b1;
               in_seg_in      = 1'b0;
            end else begin
               res.byte_kind   = seen_eq_ff ? hrlt_pkg::KIND_VALUE : hrlt_pkg::KIND_KEY;
               res.pair_index  = pair_count_ff;
               res.token_start = ~in_seg_ff;
               in_seg_in       = 1'b1;
            end
         end
         default: begin
            res.byte_kind = hrlt_pkg::KIND_IGNORED;
         end
      endcase

      res.method_code = method_in;

      // last byte of the request: back to the start
      if (q_item.payload.line_end) begin
         phase_in      = PH_METHOD;
         first_byte_in = '0;
         byte_pos_in   = '0;
         method_in     = hrlt_pkg::METHOD_UNKNOWN;
         seg_count_in  = '0;
         in_seg_in     = 1'b0;
         pair_count_in = '0;
         seen_eq_in    = 1'b0;
         path_len_in   = '0;
      end
   end

   // parser state and configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_pairs_ff  <= hrlt_pkg::MAX_PAIRS_RESET;
         phase_ff      <= PH_METHOD;
         first_byte_ff <= '0;
         byte_pos_ff   <= '0;
         method_ff     <= hrlt_pkg::METHOD_UNKNOWN;
         seg_count_ff  <= '0;
         in_seg_ff     <= 1'b0;
         pair_count_ff <= '0;
         seen_eq_ff    <= 1'b0;
         path_len_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            max_pairs_ff <= csr_wr_data;
         end
         if (q_pop) begin
            phase_ff      <= phase_in;
            first_byte_ff <= first_byte_in;
            byte_pos_ff   <= byte_pos_in;
            method_ff     <= method_in;
            seg_count_ff  <= seg_count_in;
            in_seg_ff     <= in_seg_in;
            pair_count_ff <= pair_count_in;
            seen_eq_ff    <= seen_eq_in;
            path_len_ff   <= path_len_in;
         end
      end
   end

   // result queue pointers
   always_comb begin
      res_wr_in  = res_wr_ff;
      res_rd_in  = res_rd_ff;
      res_cnt_in = res_cnt_ff;
      if (q_pop) begin
         res_wr_in = (res_wr_ff == hrlt_pkg::QPTR_W'(hrlt_pkg::QDEPTH - 1)) ?
                     '0 : res_wr_ff + hrlt_pkg::QPTR_W'(1);
      end
      if (res_pop) begin
         res_rd_in = (res_rd_ff == hrlt_pkg::QPTR_W'(hrlt_pkg::QDEPTH - 1)) ?
                     '0 : res_rd_ff + hrlt_pkg::QPTR_W'(1);
      end
      if (q_pop && !res_pop) begin
         res_cnt_in = res_cnt_ff + hrlt_pkg::QCNT_W'(1);
      end else if (!q_pop && res_pop) begin
         res_cnt_in = res_cnt_ff - hrlt_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_wr_ff  <= '0;
         res_rd_ff  <= '0;
         res_cnt_ff <= '0;
      end else begin
         res_wr_ff  <= res_wr_in;
         res_rd_ff  <= res_rd_in;
         res_cnt_ff <= res_cnt_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (q_pop) begin
         res_mem_ff[res_wr_ff] <= res;
      end
   end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HTTP request line tokeniser. Request lines are
// fed a byte at a time through the input queue. Each accepted transaction is
// run through a local tagging model that keeps its own parse state and pair
// limit. The tag it gives is queued, and every result transaction is compared
// field by field against the oldest queued tag. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int STALL_LIMIT = 4000;  // cycles without any transaction
   localparam int HOLD_CYCLES = 300;   // long receiver hold-off

   typedef enum logic [1:0] {AT_METHOD, AT_PATH, AT_QUERY, AT_TAIL} parse_phase_type;

   logic                          clock;
   logic                          reset;
   logic                          req_push;
   hrlt_pkg::req_payload_type     req_payload;
   logic                          req_full;
   logic                          rsp_empty;
   logic                          rsp_pop;
   hrlt_pkg::rsp_payload_type     rsp_payload;
   logic                          csr_wr_en;
   logic [hrlt_pkg::CNT_W-1:0]    csr_wr_data;

   // tagging model state
   parse_phase_type               phase_now;
   logic [7:0]                    lead_char;
   logic [1:0]                    method_pos;
   logic [2:0]                    method_seen;
   logic [hrlt_pkg::CNT_W-1:0]    seg_count;
   logic                          in_token;
   logic [hrlt_pkg::CNT_W-1:0]    pairs_kept;
   logic                          eq_seen;
   logic [10:0]                   path_len;
   logic [hrlt_pkg::CNT_W-1:0]    pair_limit = hrlt_pkg::MAX_PAIRS_RESET;

   hrlt_pkg::rsp_payload_type     expected_tags[$];
   logic [7:0]                    line_bytes[$];

   // stimulus controls
   bit                  tx_idling = 1'b1;
   bit                  rx_idling = 1'b1;
   int                  hold_request = 0;

   // run statistics
   int                  n_mismatches = 0;
   int                  n_results = 0;
   int                  n_bytes = 0;
   int                  n_lines = 0;
   int                  n_limit_writes = 0;
   int                  n_overflows = 0;
   int                  n_full_cycles = 0;
   int                  stuck_cycles = 0;

   http_request_line_tokenizer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_payload (req_payload),
      .req_full    (req_full),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Tagging model
   // ------------------------------------------------------------------------
   function automatic void clear_parse();
      phase_now   = AT_METHOD;
      lead_char   = '0;
      method_pos  = '0;
      method_seen = hrlt_pkg::METHOD_UNKNOWN;
      seg_count   = '0;
      in_token    = 1'b0;
      pairs_kept  = '0;
      eq_seen     = 1'b0;
      path_len    = '0;
   endfunction

   function automatic hrlt_pkg::rsp_payload_type tag_byte(input hrlt_pkg::req_payload_type req);
      hrlt_pkg::rsp_payload_type t;
      logic [7:0]                b;
      int                        lim;
      b   = req.data_byte;
      lim = (pair_limit < hrlt_pkg::MAX_PAIRS) ? pair_limit : hrlt_pkg::MAX_PAIRS;
      t   = '0;
      t.out_byte  = b;
      t.byte_kind = hrlt_pkg::KIND_IGNORED;
      t.last      = req.line_end;
      case (phase_now)
         AT_METHOD: begin
            if (method_pos == 2'd0) lead_char = b;
            // method is settled on the second byte, whatever it is
            if (method_pos == 2'd1) begin
               if (lead_char == hrlt_pkg::CHAR_G)
                  method_seen = hrlt_pkg::METHOD_GET;
               else if (lead_char == hrlt_pkg::CHAR_D)
                  method_seen = hrlt_pkg::METHOD_DELETE;
               else if (lead_char == hrlt_pkg::CHAR_P && b == hrlt_pkg::CHAR_O)
                  method_seen = hrlt_pkg::METHOD_POST;
               else if (lead_char == hrlt_pkg::CHAR_P && b == hrlt_pkg::CHAR_U)
                  method_seen = hrlt_pkg::METHOD_PUT;
               else
                  method_seen = hrlt_pkg::METHOD_UNKNOWN;
            end
            if (method_pos < 2'd2) method_pos++;
            if (b == hrlt_pkg::CHAR_SPACE) begin
               t.byte_kind = hrlt_pkg::KIND_SEP;
               phase_now   = AT_PATH;
            end else begin
               t.byte_kind = hrlt_pkg::KIND_METHOD;
            end
         end
         AT_PATH: begin
            if (b == hrlt_pkg::CHAR_SPACE) begin
               t.byte_kind = hrlt_pkg::KIND_SEP;
               phase_now   = AT_TAIL;
            end else if (b == hrlt_pkg::CHAR_QUEST) begin
               t.byte_kind = hrlt_pkg::KIND_SEP;
               phase_now   = AT_QUERY;
               in_token    = 1'b0;
               eq_seen     = 1'b0;
            end else if (path_len >= hrlt_pkg::MAX_PATH) begin
               t.overflow = 1'b1;
            end else begin
               path_len++;
               if (b == hrlt_pkg::CHAR_SLASH) begin
                  t.byte_kind = hrlt_pkg::KIND_SEP;
                  in_token    = 1'b0;
               end else if (in_token) begin
                  t.byte_kind     = hrlt_pkg::KIND_SEGMENT;
                  t.segment_index = seg_count - 1'b1;
               end else if (seg_count >= hrlt_pkg::MAX_SEGMENTS) begin
                  // whole segment dropped, every byte of it flagged
                  t.overflow = 1'b1;
               end else begin
                  t.byte_kind     = hrlt_pkg::KIND_SEGMENT;
                  t.token_start   = 1'b1;
                  t.segment_index = seg_count;
                  seg_count++;
                  in_token = 1'b1;
               end
            end
         end
         AT_QUERY: begin
            if (b == hrlt_pkg::CHAR_SPACE) begin
               t.byte_kind = hrlt_pkg::KIND_SEP;
               phase_now   = AT_TAIL;
               if (pairs_kept < lim) begin
                  t.pair_closed = 1'b1;
                  t.pair_kept   = eq_seen;
                  t.pair_index  = pairs_kept;
                  if (eq_seen) pairs_kept++;
               end
            end else if (pairs_kept >= lim) begin
               t.byte_kind = hrlt_pkg::KIND_IGNORED;
            end else if (b == hrlt_pkg::CHAR_AMP) begin
               t.byte_kind   = hrlt_pkg::KIND_SEP;
               t.pair_closed = 1'b1;
               t.pair_kept   = eq_seen;
               t.pair_index  = pairs_kept;
               if (eq_seen) pairs_kept++;
               eq_seen  = 1'b0;
               in_token = 1'b0;
            end else if (b == hrlt_pkg::CHAR_EQUAL && !eq_seen) begin
               t.byte_kind  = hrlt_pkg::KIND_SEP;
               t.pair_index = pairs_kept;
               eq_seen      = 1'b1;
               in_token     = 1'b0;
            end else begin
               t.byte_kind   = eq_seen ? hrlt_pkg::KIND_VALUE : hrlt_pkg::KIND_KEY;
               t.pair_index  = pairs_kept;
               t.token_start = !in_token;
               in_token      = 1'b1;
            end
         end
         default: t.byte_kind = hrlt_pkg::KIND_IGNORED;
      endcase
      t.method_code = method_seen;
      if (req.line_end) clear_parse();
      return t;
   endfunction

   function automatic string diff_fields(input hrlt_pkg::rsp_payload_type e,
                                         input hrlt_pkg::rsp_payload_type g);
      string s;
      s = "";
      if (e.out_byte      !== g.out_byte)      s = {s, " out_byte"};
      if (e.byte_kind     !== g.byte_kind)     s = {s, " byte_kind"};
      if (e.method_code   !== g.method_code)   s = {s, " method_code"};
      if (e.segment_index !== g.segment_index) s = {s, " segment_index"};
      if (e.pair_index    !== g.pair_index)    s = {s, " pair_index"};
      if (e.token_start   !== g.token_start)   s = {s, " token_start"};
      if (e.pair_closed   !== g.pair_closed)   s = {s, " pair_closed"};
      if (e.pair_kept     !== g.pair_kept)     s = {s, " pair_kept"};
      if (e.overflow      !== g.overflow)      s = {s, " overflow"};
      if (e.last          !== g.last)          s = {s, " last"};
      return s;
   endfunction

   function automatic string format_tag(input hrlt_pkg::rsp_payload_type t);
      return $sformatf({"byte %h kind %0d method %0d seg %0d pair %0d",
                        " start %b closed %b kept %b ovf %b last %b"},
                       t.out_byte, t.byte_kind, t.method_code, t.segment_index,
                       t.pair_index, t.token_start, t.pair_closed, t.pair_kept,
                       t.overflow, t.last);
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: predicts on input transactions, checks result transactions,
   // and runs the watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      hrlt_pkg::rsp_payload_type want;
      string                     bad;
      bit                        moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_push && req_full) n_full_cycles++;
         if (req_push && !req_full) begin
            want = tag_byte(req_payload);
            if (want.overflow) n_overflows++;
            expected_tags.push_back(want);
            moved = 1'b1;
         end
         if (rsp_pop && !rsp_empty) begin
            moved = 1'b1;
            n_results++;
            if (expected_tags.size() == 0) begin
               if (n_mismatches < 10)
                  $display("[%0t] result with no transaction waiting: %s", $realtime,
                           format_tag(rsp_payload));
               n_mismatches++;
            end else begin
               want = expected_tags.pop_front();
               bad  = diff_fields(want, rsp_payload);
               if (bad != "") begin
                  if (n_mismatches < 10) begin
                     $display("[%0t] mismatch on result %0d, fields:%s",
                              $realtime, n_results, bad);
                     $display("   expected %s", format_tag(want));
                     $display("   actual   %s", format_tag(rsp_payload));
                  end
                  n_mismatches++;
               end
            end
         end
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STALL_LIMIT) begin
         $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, STALL_LIMIT);
         $display("http_request_line_tokenizer regression: fail");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------------
   // Receiver: random stalls plus an optional long hold-off
   // ------------------------------------------------------------------------
   initial begin : receiver
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (rx_idling && $urandom_range(0, 99) < 20) begin
            stall_left = pick_gap() - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender helpers
   // ------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b, input logic line_end);
      int gap;
      gap = (tx_idling && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push              <= 1'b1;
      req_payload.data_byte <= b;
      req_payload.line_end  <= line_end;
      do @(posedge clock); while (req_full);
      n_bytes++;
   endtask

   task automatic send_line(input bit close);
      for (int i = 0; i < line_bytes.size(); i++)
         push_byte(line_bytes[i], close && (i == line_bytes.size() - 1));
      n_lines++;
      line_bytes.delete();
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
   endtask

   task automatic send_text(input string s);
      add_text(s);
      send_line(1'b1);
   endtask

   function automatic logic [7:0] token_char();
      logic [7:0] c;
      if ($urandom_range(0, 99) < 85) begin
         c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'h30, 8'h39))
                                         : 8'($urandom_range(8'h61, 8'h7A));
      end else begin
         c = 8'($urandom_range(0, 255));
         if (c == hrlt_pkg::CHAR_SPACE || c == hrlt_pkg::CHAR_QUEST ||
             c == hrlt_pkg::CHAR_AMP || c == hrlt_pkg::CHAR_EQUAL ||
             c == hrlt_pkg::CHAR_SLASH)
            c = 8'h2D;
      end
      return c;
   endfunction

   task automatic add_token(input int n);
      repeat (n) line_bytes.push_back(token_char());
   endtask

   // drain everything in flight, then let the parser settle
   task automatic wait_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_tags.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_pair_limit(input logic [hrlt_pkg::CNT_W-1:0] v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      pair_limit = v;
      n_limit_writes++;
   endtask

   // mostly well-formed lines with random content; some noise and truncation
   task automatic build_random_line();
      int pick;
      int n;
      line_bytes.delete();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         repeat ($urandom_range(1, 16)) line_bytes.push_back(8'($urandom_range(0, 255)));
         return;
      end
      case ($urandom_range(0, 7))
         0: add_text("GET");
         1: add_text("DELETE");
         2: add_text("POST");
         3: add_text("PUT");
         4: add_text("PATCH");
         5: add_text("OPTIONS");
         6: ;
         default: add_token($urandom_range(1, 3));
      endcase
      if ($urandom_range(0, 19) != 0) add_text(" ");
      n = $urandom_range(0, 5);
      repeat (n) begin
         add_text("/");
         if ($urandom_range(0, 9) == 0) add_text("/");
         add_token($urandom_range(1, 6));
      end
      if (n == 0 || $urandom_range(0, 7) == 0) add_text("/");
      if ($urandom_range(0, 9) < 6) begin
         add_text("?");
         n = $urandom_range(0, 6);
         for (int i = 0; i < n; i++) begin
            if (i > 0) add_text("&");
            add_token($urandom_range(0, 4));
            if ($urandom_range(0, 9) < 8) begin
               add_text("=");
               add_token($urandom_range(0, 4));
               if ($urandom_range(0, 9) == 0) begin
                  add_text("=");
                  add_token($urandom_range(1, 2));
               end
            end
         end
      end
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, line_bytes.size());
         while (line_bytes.size() > n) void'(line_bytes.pop_back());
         return;
      end
      if ($urandom_range(0, 9) < 7) begin
         add_text(" HTTP/1.1");
      end else begin
         add_text(" ");
         repeat ($urandom_range(0, 6)) line_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // every method code, decode on a space
   task automatic test_methods();
      send_text("G ");
      send_text("D ");
      send_text("PO ");
      send_text("PU ");
      send_text("PX");
      line_bytes.push_back(8'hFF);
      line_bytes.push_back(8'h00);
      send_line(1'b1);
   endtask

   // empty segment, dropped pair, empty key, second equals in a value
   task automatic test_query_shapes();
      send_text(" /a//b?k=v&d&=w= y");
   endtask

   // pair limit at its extremes, with lines that also end inside the query
   task automatic test_pair_limit();
      logic [hrlt_pkg::CNT_W-1:0] limits[5] = '{6'd0, 6'd1, 6'd2, 6'd63, 6'd32};
      foreach (limits[i]) begin
         set_pair_limit(limits[i]);
         send_text("GET /p?a=1&b&c=2&d=3&e=4 x");
         send_text("PUT /?k=v&m=n");
      end
   endtask

   task automatic test_segment_limit();
      add_text("GET /");
      repeat (35) add_text("sg/");
      add_text("x?a=b HTTP/1.1");
      send_line(1'b1);
   endtask

   task automatic test_path_limit();
      add_text("PUT /");
      for (int i = 0; i < 1040; i++)
         line_bytes.push_back((i % 50 == 49) ? hrlt_pkg::CHAR_SLASH : token_char());
      add_text("?k=v&q ");
      send_line(1'b1);
   endtask

   // receiver holds off while the sender keeps offering: both queues fill
   task automatic test_backpressure();
      wait_idle();
      tx_idling    = 1'b0;
      hold_request = HOLD_CYCLES;
      send_text("GET /fill/the/queues?a=b&c=d HTTP/1.1");
      wait_idle();
      tx_idling = 1'b1;
   endtask

   task automatic test_random();
      int items;
      int chunk;
      int pick;
      items = 0;
      chunk = 0;
      while (items < 700) begin
         if (chunk % 8 == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)       set_pair_limit(6'($urandom_range(0, 3)));
            else if (pick < 6)  set_pair_limit(6'($urandom_range(4, 8)));
            else if (pick == 6) set_pair_limit(6'd0);
            else if (pick == 7) set_pair_limit(6'd63);
            else                set_pair_limit(6'($urandom_range(9, 63)));
            tx_idling = ($urandom_range(0, 3) != 0);
            rx_idling = ($urandom_range(0, 3) != 0);
         end
         build_random_line();
         items += line_bytes.size();
         send_line($urandom_range(0, 19) != 0);
         chunk++;
      end
      tx_idling = 1'b1;
      rx_idling = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      clear_parse();
      req_push    <= 1'b0;
      req_payload <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      reset       <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_methods();
      test_query_shapes();
      test_pair_limit();
      test_segment_limit();
      test_path_limit();
      test_backpressure();
      test_random();

      wait_idle();
      repeat (10) @(posedge clock);

      $display("covered %0d lines, %0d bytes, %0d pair-limit writes, %0d overflow tags",
               n_lines, n_bytes, n_limit_writes, n_overflows);
      $display("%0d tags checked, input blocked by a full queue for %0d cycles",
               n_results, n_full_cycles);
      if (n_mismatches == 0 && expected_tags.size() == 0) begin
         $display("http_request_line_tokenizer regression: pass");
      end else begin
         $display("%0d mismatches, %0d tags never seen", n_mismatches, expected_tags.size());
         $display("http_request_line_tokenizer regression: fail");
      end
      $finish;
   end

endmodule
